// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL of the face normal block.
// Depends on a clock named i_clk and an active-low reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- rtl/core/tfn_pkg.sv -----
// Package of the triangle face normal block: widths and the tag type.
// Used by tfn_norm_lane and triangle_face_normal_top; depends on nothing.
package tfn_pkg;
    localparam int COORD_W   = 16;
    localparam int FRAC_BITS = 14;
    localparam int NORM_W    = 16;
    localparam int N_COORD   = 9;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int MAG_W     = PROD_W - 1;
    localparam int HALF_W    = (MAG_W + 1) / 2;
    localparam int HI_W      = MAG_W - HALF_W;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int RHS_W     = SQ_W + 2 * FRAC_BITS + 2;
    localparam int ITER_W    = SUM_W + 2 * FRAC_BITS + 5;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int IN_TW     = ((N_COORD * COORD_W + 7) / 8) * 8;
    localparam int OUT_TW    = ((3 * NORM_W + 7) / 8) * 8;
    localparam int N_FRONT   = 6;
    localparam int N_VLD     = N_FRONT + Q_W;
    localparam int N_TAG     = N_VLD - 2;

    typedef struct packed {
        logic [2:0] neg;
        logic       ok;
    } t_tag;
endpackage

// ----- rtl/core/tfn_norm_lane.sv -----
// One normalization lane: bit-serial rounded |c|*2^F/sqrt(s), one bit per stage.
// Depends on tfn_pkg.
module tfn_norm_lane
    import tfn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [SUM_W-1:0]   i_sum,
    input  logic [RHS_W-1:0]   i_rhs,
    output logic [Q_W-1:0]     o_q
);
    logic signed [ITER_W-1:0] r_a [Q_W];
    logic signed [ITER_W-1:0] r_b [Q_W];
    logic signed [ITER_W-1:0] r_s [Q_W];
    logic signed [ITER_W-1:0] r_r [Q_W];
    logic        [Q_W-1:0]    r_q [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        localparam int BIT = FRAC_BITS - k;
        logic signed [ITER_W-1:0] w_a, w_b, w_s, w_r, w_trial;
        logic        [Q_W-1:0]    w_q;
        logic                     w_take;
        if (k == 0) begin : g_first
            assign w_s = signed'(ITER_W'(i_sum));
            assign w_r = signed'(ITER_W'(i_rhs));
            assign w_a = w_s;
            assign w_b = -w_s;
            assign w_q = '0;
        end else begin : g_next
            assign w_s = r_s[k-1];
            assign w_r = r_r[k-1];
            assign w_a = r_a[k-1];
            assign w_b = r_b[k-1];
            assign w_q = r_q[k-1];
        end
        assign w_trial = w_a + (w_b <<< (BIT + 2)) + (w_s <<< (2 * BIT + 2));
        assign w_take  = (w_trial <= w_r) && !((BIT < FRAC_BITS) && w_q[FRAC_BITS]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[k] <= w_s;
                r_r[k] <= w_r;
                r_a[k] <= w_take ? w_trial : w_a;
                r_b[k] <= w_take ? (w_b + (w_s <<< (BIT + 1))) : w_b;
                r_q[k] <= w_take ? (w_q | (Q_W'(1) << BIT)) : w_q;
            end
        end
    end

    assign o_q = r_q[Q_W-1];
endmodule

// ----- rtl/core/triangle_face_normal_top.sv -----
// Top level of the triangle face normal block: cross product, squares and lanes.
// Depends on tfn_pkg, tfn_norm_lane and assert_macros.svh.
//
//  channel     | dir | fields (lowest bits first)
//  ------------+-----+-------------------------------------------------------
//  s_axis      | in  | tdata: p1_x p1_y p1_z p2_x p2_y p2_z p3_x p3_y p3_z
//  m_axis      | out | tdata: normal_x normal_y normal_z; tuser: normal_ok
//
// One transfer in per cycle while the output is not stalled.
// Rate set by the fully pipelined datapath: one result bit per lane stage.
// Reset clears only the valid bits; payload registers hold whatever they had.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
`include "assert_macros.svh"
module triangle_face_normal_top
    import tfn_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [IN_TW-1:0]    i_s_axis_tdata,   // p1_x p1_y p1_z p2_x p2_y p2_z p3_x p3_y p3_z
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [OUT_TW-1:0]   o_m_axis_tdata,   // normal_x normal_y normal_z
    output logic [0:0]          o_m_axis_tuser    // normal_ok
);
    logic                      w_en;
    logic [N_VLD-1:0]          r_vld;
    t_tag                      r_tag [N_TAG];
    logic                      r_out_vld;
    logic [OUT_TW-1:0]         r_out_data;
    logic                      r_out_ok;

    logic signed [COORD_W-1:0] w_p [N_COORD];
    logic signed [DIFF_W-1:0]  r_d [6];
    logic signed [PROD_W-1:0]  r_p [6];
    logic [MAG_W-1:0]          r_mag [3];
    logic [2*HI_W-1:0]         r_hh [3];
    logic [HI_W+HALF_W-1:0]    r_hl [3];
    logic [2*HALF_W-1:0]       r_ll [3];
    logic [SQ_W-1:0]           r_sq [3];
    logic [SUM_W-1:0]          r_sum;
    logic [RHS_W-1:0]          r_rhs [3];
    logic [Q_W-1:0]            w_q [3];
    logic signed [PROD_W-1:0]  w_c [3];
    logic [NORM_W-1:0]         n_norm [3];

    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    for (genvar i = 0; i < N_COORD; i++) begin : g_unpack
        assign w_p[i] = signed'(i_s_axis_tdata[i*COORD_W +: COORD_W]);
    end

    assign w_c[0] = r_p[0] - r_p[1];
    assign w_c[1] = r_p[2] - r_p[3];
    assign w_c[2] = r_p[4] - r_p[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[N_VLD-2:0], i_s_axis_tvalid};
            r_out_vld <= r_vld[N_VLD-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // a = p3 - p1 at 0..2, b = p2 - p1 at 3..5
            r_d[0] <= DIFF_W'(w_p[6]) - DIFF_W'(w_p[0]);
            r_d[1] <= DIFF_W'(w_p[7]) - DIFF_W'(w_p[1]);
            r_d[2] <= DIFF_W'(w_p[8]) - DIFF_W'(w_p[2]);
            r_d[3] <= DIFF_W'(w_p[3]) - DIFF_W'(w_p[0]);
            r_d[4] <= DIFF_W'(w_p[4]) - DIFF_W'(w_p[1]);
            r_d[5] <= DIFF_W'(w_p[5]) - DIFF_W'(w_p[2]);

            r_p[0] <= r_d[1] * r_d[5];
            r_p[1] <= r_d[2] * r_d[4];
            r_p[2] <= r_d[2] * r_d[3];
            r_p[3] <= r_d[0] * r_d[5];
            r_p[4] <= r_d[0] * r_d[4];
            r_p[5] <= r_d[1] * r_d[3];

            for (int k = 0; k < 3; k++) begin
                r_mag[k] <= w_c[k][PROD_W-1] ? MAG_W'(-w_c[k]) : MAG_W'(w_c[k]);
                r_hh[k]  <= r_mag[k][MAG_W-1:HALF_W] * r_mag[k][MAG_W-1:HALF_W];
                r_hl[k]  <= r_mag[k][MAG_W-1:HALF_W] * r_mag[k][HALF_W-1:0];
                r_ll[k]  <= r_mag[k][HALF_W-1:0] * r_mag[k][HALF_W-1:0];
                r_sq[k]  <= (SQ_W'(r_hh[k]) << (2 * HALF_W))
                          + (SQ_W'(r_hl[k]) << (HALF_W + 1)) + SQ_W'(r_ll[k]);
                r_rhs[k] <= RHS_W'(r_sq[k]) << (2 * FRAC_BITS + 2);
            end
            r_sum <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);

            r_tag[0].neg <= {w_c[2][PROD_W-1], w_c[1][PROD_W-1], w_c[0][PROD_W-1]};
            r_tag[0].ok  <= (w_c[0] != '0) || (w_c[1] != '0) || (w_c[2] != '0);
            for (int t = 1; t < N_TAG; t++) begin
                r_tag[t] <= r_tag[t-1];
            end

            r_out_data <= OUT_TW'({n_norm[2], n_norm[1], n_norm[0]});
            r_out_ok   <= r_tag[N_TAG-1].ok;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic signed [Q_W:0] w_sv;
        tfn_norm_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_sum (r_sum),
            .i_rhs (r_rhs[k]),
            .o_q   (w_q[k])
        );
        assign w_sv      = r_tag[N_TAG-1].neg[k] ? -signed'({1'b0, w_q[k]})
                                                 : signed'({1'b0, w_q[k]});
        assign n_norm[k] = r_tag[N_TAG-1].ok ? NORM_W'(w_sv) : '0;
    end

    assign o_m_axis_tvalid   = r_out_vld;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_ok;

    `ASSERT_CLK(a_degen_zero, (r_out_vld && !r_out_ok) |-> (r_out_data == '0),
        "degenerate triangle gave a nonzero normal")
    `ASSERT_CLK(a_ok_nonzero, (r_out_vld && r_out_ok) |-> (r_out_data != '0),
        "valid normal is all zero")
    `ASSERT_NEXT(a_enter, i_s_axis_tvalid && o_s_axis_tready, r_vld[0],
        "accepted transfer did not enter the pipeline")
endmodule
